FILE: rtl/monic_quadratic_root_solver_defines.svh
// assertion macros for the monic quadratic root solver
// both expect a clock named clk and an active-high reset named rst in scope
`ifndef MONIC_QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define MONIC_QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication
`define MQRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MQRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mqrs_pkg.sv
package mqrs_pkg;

  // default coefficient format, signed Q16.16
  localparam int DEF_COEF_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;

  // result sideband layout
  localparam int OUT_USER_W       = 2;
  localparam int USER_COMPLEX_BIT = 0;
  localparam int USER_SAT_BIT     = 1;

  // round a bit count up to whole bytes
  function automatic int pad_bytes(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

  // magnitude width of the exact discriminant p*p - 4q
  function automatic int disc_width(input int cw, input int fb);
    int a;
    int b;
    a = 2 * cw;
    b = cw + fb + 2;
    return ((a > b) ? a : b) + 1;
  endfunction

  // width of the floor square root of the discriminant magnitude
  function automatic int root_width(input int cw, input int fb);
    return (disc_width(cw, fb) + 1) / 2;
  endfunction

endpackage

FILE: rtl/mqrs_sqrt_stage.sv
module mqrs_sqrt_stage #(
  parameter int DISC_W = mqrs_pkg::disc_width(mqrs_pkg::DEF_COEF_WIDTH,
                                              mqrs_pkg::DEF_FRAC_BITS),
  parameter int ROOT_W = mqrs_pkg::root_width(mqrs_pkg::DEF_COEF_WIDTH,
                                              mqrs_pkg::DEF_FRAC_BITS),
  parameter int BIT    = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DISC_W-1:0] rem_in,
  input  logic [ROOT_W-1:0] root_in,
  output logic [DISC_W-1:0] rem_out,
  output logic [ROOT_W-1:0] root_out
);

  import mqrs_pkg::*;

  localparam int TW = 2 * ROOT_W + 1;

  logic [TW-1:0] trial;
  logic [TW-1:0] rem_ext;
  logic          take;

  // trial subtrahend (2*root + 2^bit) * 2^bit, root bits below this one are zero
  always_comb begin
    trial   = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    rem_ext = TW'(rem_in);
    take    = (rem_ext >= trial);
  end

  // one root bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        rem_out  <= DISC_W'(rem_ext - trial);
        root_out <= root_in | (ROOT_W'(1) << BIT);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end

endmodule

FILE: rtl/monic_quadratic_root_solver.sv
// stages: coefficient split, discriminant, sign and magnitude, a square root stage
//   per root bit, and the halved, clamped output register
// throughput: one equation per cycle unless stalled, set by the sqrt pipeline
// each stage holds its item until the next stage has room; bubbles are squeezed out
// reset: synchronous, clears every stage valid flag; data registers are not reset
module monic_quadratic_root_solver #(
  parameter int COEF_WIDTH = mqrs_pkg::DEF_COEF_WIDTH,
  parameter int FRAC_BITS  = mqrs_pkg::DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // coef_linear, coef_const
  input  logic [mqrs_pkg::pad_bytes(2*COEF_WIDTH)-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // first_value, second_value
  output logic [mqrs_pkg::pad_bytes(2*COEF_WIDTH)-1:0] m_axis_tdata,
  // is_complex, saturated
  output logic [mqrs_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  import mqrs_pkg::*;

  localparam int W      = COEF_WIDTH;
  localparam int DATA_W = pad_bytes(2 * W);
  localparam int DW     = disc_width(W, FRAC_BITS);
  localparam int DW1    = DW + 1;
  localparam int SW     = root_width(W, FRAC_BITS);
  localparam int H      = (W + 1) / 2;
  localparam int HW     = W - H;
  localparam int K      = FRAC_BITS + 2;
  localparam int RW     = ((W + 1 > SW + 1) ? W + 1 : SW + 1) + 1;
  localparam int NSTG   = SW + 4;
  localparam int OUT    = NSTG - 1;

  localparam logic signed [RW-1:0] OUT_MAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] OUT_MIN = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};

  // stage valid flags and advance chain
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_in;
  logic [NSTG-1:0] adv;

  assign vld_in        = {vld[NSTG-2:0], s_axis_tvalid};
  assign adv[OUT]      = !vld[OUT] || m_axis_tready;
  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[OUT];

  for (genvar i = 0; i < NSTG - 1; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // stage 1: magnitude split, partial products of p*p, 4q aligned
  logic signed [W-1:0]   p_in;
  logic signed [W-1:0]   q_in;
  logic        [W-1:0]   pmag;
  logic        [H-1:0]   pm_lo;
  logic        [HW-1:0]  pm_hi;
  logic        [2*H-1:0] st1_pp_ll;
  logic        [W-1:0]   st1_pp_hl;
  logic        [2*HW-1:0] st1_pp_hh;
  logic signed [DW1-1:0] st1_qs;
  logic signed [W:0]     st1_negp;

  always_comb begin
    p_in  = $signed(s_axis_tdata[W-1:0]);
    q_in  = $signed(s_axis_tdata[2*W-1:W]);
    pmag  = p_in[W-1] ? W'(-p_in) : W'(p_in);
    pm_lo = pmag[H-1:0];
    pm_hi = pmag[W-1:H];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st1_pp_ll <= pm_lo * pm_lo;
      st1_pp_hl <= pm_hi * pm_lo;
      st1_pp_hh <= pm_hi * pm_hi;
      st1_qs    <= DW1'(q_in) <<< K;
      st1_negp  <= -((W+1)'(p_in));
    end
  end

  // stage 2: signed discriminant
  logic signed [DW1-1:0] st2_d;
  logic signed [W:0]     st2_negp;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      st2_d    <= $signed((DW1'(st1_pp_hh) << (2 * H)) + (DW1'(st1_pp_hl) << (H + 1))
                          + DW1'(st1_pp_ll)) - st1_qs;
      st2_negp <= st1_negp;
    end
  end

  // stage 3: sign and magnitude
  logic [DW-1:0]     st3_mag;
  logic              st3_neg;
  logic signed [W:0] st3_negp;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      st3_neg  <= st2_d[DW];
      st3_mag  <= st2_d[DW] ? DW'(-st2_d) : DW'(st2_d);
      st3_negp <= st2_negp;
    end
  end

  // square root, one bit per stage
  logic [DW-1:0]     rem_w  [SW+1];
  logic [SW-1:0]     root_w [SW+1];
  logic              side_neg  [SW];
  logic signed [W:0] side_negp [SW];

  assign rem_w[0]  = st3_mag;
  assign root_w[0] = '0;

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    mqrs_sqrt_stage #(
      .DISC_W (DW),
      .ROOT_W (SW),
      .BIT    (SW - 1 - j)
    ) u_stage (
      .clk      (clk),
      .en       (adv[3+j]),
      .rem_in   (rem_w[j]),
      .root_in  (root_w[j]),
      .rem_out  (rem_w[j+1]),
      .root_out (root_w[j+1])
    );

    // sign and -p travel beside the root
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv[3]) begin
          side_neg[0]  <= st3_neg;
          side_negp[0] <= st3_negp;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv[3+j]) begin
          side_neg[j]  <= side_neg[j-1];
          side_negp[j] <= side_negp[j-1];
        end
      end
    end
  end

  // output stage: roots or real and imaginary parts, halved and clamped
  logic signed [RW-1:0] negp_x;
  logic signed [RW-1:0] s_x;
  logic signed [RW-1:0] lo_sum;
  logic signed [RW-1:0] hi_sum;
  logic signed [RW-1:0] lo_half;
  logic signed [RW-1:0] hi_half;
  logic        [W-1:0]  first_value;
  logic        [W-1:0]  second_value;
  logic                 lo_sat;
  logic                 hi_sat;
  logic                 is_neg;

  always_comb begin
    is_neg  = side_neg[SW-1];
    negp_x  = RW'(side_negp[SW-1]);
    s_x     = $signed(RW'(root_w[SW]));
    lo_sum  = is_neg ? negp_x : negp_x - s_x;
    hi_sum  = is_neg ? s_x : negp_x + s_x;
    lo_half = lo_sum >>> 1;
    hi_half = hi_sum >>> 1;
    lo_sat  = (lo_half > OUT_MAX) || (lo_half < OUT_MIN);
    hi_sat  = (hi_half > OUT_MAX) || (hi_half < OUT_MIN);
    if (lo_half > OUT_MAX) begin
      first_value = W'(OUT_MAX);
    end else if (lo_half < OUT_MIN) begin
      first_value = W'(OUT_MIN);
    end else begin
      first_value = W'(lo_half);
    end
    if (hi_half > OUT_MAX) begin
      second_value = W'(OUT_MAX);
    end else if (hi_half < OUT_MIN) begin
      second_value = W'(OUT_MIN);
    end else begin
      second_value = W'(hi_half);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT]) begin
      m_axis_tdata                   <= DATA_W'({second_value, first_value});
      m_axis_tuser[USER_COMPLEX_BIT] <= is_neg;
      m_axis_tuser[USER_SAT_BIT]     <= lo_sat || hi_sat;
    end
  end

endmodule

FILE: rtl/mqrs_checker.sv
`include "monic_quadratic_root_solver_defines.svh"

module mqrs_checker #(
  parameter int COEF_WIDTH = mqrs_pkg::DEF_COEF_WIDTH
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  // first_value, second_value
  input logic [mqrs_pkg::pad_bytes(2*COEF_WIDTH)-1:0] m_axis_tdata,
  // is_complex, saturated
  input logic [mqrs_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  import mqrs_pkg::*;

  localparam int W = COEF_WIDTH;

  // a stalled result holds
  `MQRS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // input back-pressure only when the output is full and stalled
  `MQRS_ASSERT_IMP(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with room in the pipeline")

  // real roots come out in order
  `MQRS_ASSERT_IMP(a_root_order, m_axis_tvalid && !m_axis_tuser[USER_COMPLEX_BIT], $signed(m_axis_tdata[W-1:0]) <= $signed(m_axis_tdata[2*W-1:W]), "real roots out of order")

  // imaginary magnitude is never negative
  `MQRS_ASSERT_IMP(a_imag_sign, m_axis_tvalid && m_axis_tuser[USER_COMPLEX_BIT], !m_axis_tdata[2*W-1], "negative imaginary part")

endmodule

bind monic_quadratic_root_solver mqrs_checker #(.COEF_WIDTH(COEF_WIDTH)) u_mqrs_checker (.*);

FILE: tb/sv/monic_root_checker.sv
module monic_root_checker #(
  parameter int COEF_WIDTH = mqrs_pkg::DEF_COEF_WIDTH,
  parameter int FRAC_BITS  = mqrs_pkg::DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  // coef_linear, coef_const
  input  logic [mqrs_pkg::pad_bytes(2*COEF_WIDTH)-1:0] s_axis_tdata,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  // first_value, second_value
  input  logic [mqrs_pkg::pad_bytes(2*COEF_WIDTH)-1:0] m_axis_tdata,
  // is_complex, saturated
  input  logic [mqrs_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output int error_count,
  output int roots_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW  = COEF_WIDTH;
  // discriminant width with headroom for p*p and the aligned 4q
  localparam int DW  = 2*CW + FRAC_BITS + 4;
  localparam int RW  = DW/2 + 1;
  localparam int SQW = 2*RW;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [CW-1:0] coef_p;
    logic signed [CW-1:0] coef_q;
    logic                 is_complex;
    logic signed [CW-1:0] first_value;
    logic signed [CW-1:0] second_value;
    logic                 saturated;
  } root_set_t;

  root_set_t pending_roots[$];
  root_set_t want;
  root_set_t got;
  int        mismatches = 0;

  // clamp to the signed coefficient range, flagging any clipping
  function automatic logic signed [CW-1:0] clip_fixed(input logic signed [DW-1:0] v,
                                                      inout logic clipped);
    logic signed [DW-1:0] top_v;
    logic signed [DW-1:0] bot_v;
    top_v = '0;
    top_v[CW-2:0] = '1;
    bot_v = ~top_v;
    if (v > top_v) begin
      clipped = 1'b1;
      return top_v[CW-1:0];
    end
    if (v < bot_v) begin
      clipped = 1'b1;
      return bot_v[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // roots of x^2 + p*x + q with an exact discriminant and floor square root
  function automatic root_set_t solve_monic(input logic signed [CW-1:0] p,
                                            input logic signed [CW-1:0] q);
    logic signed [DW-1:0] pw;
    logic signed [DW-1:0] qw;
    logic signed [DW-1:0] disc;
    logic signed [DW-1:0] s_w;
    logic signed [DW-1:0] negp;
    logic signed [DW-1:0] lo_v;
    logic signed [DW-1:0] hi_v;
    logic [SQW-1:0]       mag;
    logic [SQW-1:0]       root;
    logic [SQW-1:0]       trial;
    logic                 clipped;
    root_set_t            r;
    pw   = p;
    qw   = q;
    // 4q carries twice the fraction bits to line up with p*p
    disc = pw * pw - (qw <<< (FRAC_BITS + 2));
    mag  = (disc < 0) ? SQW'(-disc) : SQW'(disc);
    // bit-by-bit floor square root
    root = '0;
    for (int b = RW - 1; b >= 0; b--) begin
      trial = root | (SQW'(1) << b);
      if (trial * trial <= mag) root = trial;
    end
    s_w     = DW'(root);
    negp    = -pw;
    clipped = 1'b0;
    r.coef_p     = p;
    r.coef_q     = q;
    r.is_complex = (disc < 0);
    // halving is an arithmetic shift, rounding toward minus infinity
    if (r.is_complex) begin
      lo_v = negp >>> 1;
      hi_v = s_w >>> 1;
    end else begin
      lo_v = (negp - s_w) >>> 1;
      hi_v = (negp + s_w) >>> 1;
    end
    r.first_value  = clip_fixed(lo_v, clipped);
    r.second_value = clip_fixed(hi_v, clipped);
    r.saturated    = clipped;
    return r;
  endfunction

  // watch both channels, predict on input and compare on output
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got              = '0;
        got.is_complex   = m_axis_tuser[mqrs_pkg::USER_COMPLEX_BIT];
        got.first_value  = m_axis_tdata[CW-1:0];
        got.second_value = m_axis_tdata[2*CW-1:CW];
        got.saturated    = m_axis_tuser[mqrs_pkg::USER_SAT_BIT];
        if (pending_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result transaction with no equation pending", $realtime);
            $display("  actual   complex=%0b first=%0d second=%0d sat=%0b",
                     got.is_complex, $signed(got.first_value),
                     $signed(got.second_value), got.saturated);
          end
        end else begin
          want = pending_roots.pop_front();
          if (got.is_complex !== want.is_complex || got.first_value !== want.first_value ||
              got.second_value !== want.second_value || got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: root mismatch for p=%h q=%h", $realtime, want.coef_p, want.coef_q);
              $display("  expected complex=%0b first=%0d second=%0d sat=%0b",
                       want.is_complex, $signed(want.first_value),
                       $signed(want.second_value), want.saturated);
              $display("  actual   complex=%0b first=%0d second=%0d sat=%0b",
                       got.is_complex, $signed(got.first_value),
                       $signed(got.second_value), got.saturated);
            end
          end
        end
      end
      // queue the prediction for this equation behind the ones in flight
      if (s_axis_tvalid && s_axis_tready)
        pending_roots = {pending_roots,
                         solve_monic(s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW])};
    end
    error_count       <= mismatches;
    roots_outstanding <= pending_roots.size();
  end

endmodule

FILE: tb/sv/tb_monic_quadratic_root_solver.sv
module tb_monic_quadratic_root_solver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW     = mqrs_pkg::DEF_COEF_WIDTH;
  localparam int FB     = mqrs_pkg::DEF_FRAC_BITS;
  localparam int DATA_W = mqrs_pkg::pad_bytes(2*CW);
  localparam int RANDOM_EQUATIONS = 1450;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 80;
  localparam int IDLE_PERCENT     = 19;
  localparam logic [CW-1:0] FIX_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] FIX_MIN = {1'b1, {(CW-1){1'b0}}};

  logic              clk;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic [mqrs_pkg::OUT_USER_W-1:0] m_axis_tuser;

  bit quiet       = 1'b0;
  int cycle_count = 0;
  int error_count;
  int roots_outstanding;

  monic_quadratic_root_solver dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  monic_root_checker root_check (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .error_count       (error_count),
    .roots_outstanding (roots_outstanding)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_monic_quadratic_root_solver: errors");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  function automatic bit idle_slot();
    return !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  function automatic logic [CW-1:0] fixed_of(input int whole);
    return CW'(whole) << FB;
  endfunction

  // uniform value within +/-256.0
  function automatic logic [CW-1:0] small_fixed();
    return CW'($urandom_range(0, 1 << 25)) - CW'(1 << 24);
  endfunction

  function automatic logic [CW-1:0] corner_fixed();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return FIX_MIN;
      2: return FIX_MAX;
      3: return '1;
      4: return CW'(1);
      default: return fixed_of(1);
    endcase
  endfunction

  // one equation transaction, with random gaps before it
  task automatic send_equation(input logic [CW-1:0] p, input logic [CW-1:0] q);
    while (idle_slot()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'({q, p});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold off until every predicted root set has been returned
  task automatic drain_roots();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (roots_outstanding != 0) @(posedge clk);
  endtask

  // mix of raw words, corners, small values, known roots and near-double roots
  task automatic random_equation(output logic [CW-1:0] p, output logic [CW-1:0] q);
    logic signed [63:0] r1;
    logic signed [63:0] r2;
    logic signed [63:0] prod;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      p = $urandom;
      q = $urandom;
    end else if (pick < 38) begin
      p = corner_fixed();
      q = corner_fixed();
    end else if (pick < 60) begin
      p = small_fixed();
      q = small_fixed();
    end else if (pick < 82) begin
      r1   = $signed(small_fixed()) >>> 1;
      r2   = $signed(small_fixed()) >>> 1;
      p    = CW'(-(r1 + r2));
      prod = r1 * r2;
      q    = CW'(prod >>> FB);
    end else begin
      p    = small_fixed();
      prod = $signed(p) * $signed(p);
      q    = CW'(prod >>> (FB + 2)) + CW'($urandom_range(0, 4)) - CW'(2);
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [CW-1:0] p;
    logic [CW-1:0] q;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: double roots, odd halving, complex pairs, clipping, bit patterns
    send_equation('0, '0);
    send_equation('0, fixed_of(1));
    send_equation(fixed_of(-3), fixed_of(2));
    send_equation(fixed_of(2), fixed_of(1));
    send_equation(fixed_of(4), fixed_of(4));
    send_equation(CW'(1), '0);
    send_equation('1, '0);
    send_equation(CW'(1), CW'(1));
    send_equation(FIX_MAX, '0);
    send_equation(FIX_MIN, '0);
    send_equation(FIX_MIN, FIX_MIN);
    send_equation(FIX_MAX, FIX_MIN);
    send_equation(FIX_MIN, FIX_MAX);
    send_equation('0, FIX_MAX);
    send_equation('0, FIX_MIN);
    send_equation(FIX_MAX, FIX_MAX);
    send_equation(32'h5555_5555, 32'hAAAA_AAAA);
    send_equation(32'hAAAA_AAAA, 32'h5555_5555);
    send_equation('1, '1);

    // random equations, with a full drain and a stretch with no gaps
    for (int n = 0; n < RANDOM_EQUATIONS; n++) begin
      if (n == 400) drain_roots();
      if (n == 700) quiet <= 1'b1;
      if (n == 900) quiet <= 1'b0;
      random_equation(p, q);
      send_equation(p, q);
    end

    drain_roots();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && roots_outstanding == 0) begin
      $display("tb_monic_quadratic_root_solver: clean");
    end else begin
      $display("tb_monic_quadratic_root_solver: errors");
    end
    $finish;
  end

endmodule
